[src/mwap_pkg.sv]
// Shared constants and register indexes for the window alarm panel.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mwap_pkg;

  // Channel count and sample width used by the datapath
  localparam int CHANNELS  = 8;
  localparam int SAMPLE_W  = 10;
  // Fixed field widths of the ports
  localparam int BTN_W     = 8;
  localparam int TICKS_W   = 16;
  localparam int WIN_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_TICKS = 2'd3;

  // Register values after reset
  localparam logic [TICKS_W-1:0] PRESS_TICKS_RST = 16'd25;
  localparam logic [WIN_W-1:0]   WINDOW_HIGH_RST = 10'd550;
  localparam logic [WIN_W-1:0]   WINDOW_LOW_RST  = 10'd497;
  localparam logic [TICKS_W-1:0] BLINK_TICKS_RST = 16'd2000;

endpackage

`default_nettype wire

[src/mwap_if.sv]
// Handshake interfaces for the tick words and the result words.
// Depends on mwap_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mwap_tick_if;
  import mwap_pkg::*;
  logic                valid;
  logic                ready;
  logic [BTN_W-1:0]    button_levels;
  logic [SAMPLE_W-1:0] sample_ch0;
  logic [SAMPLE_W-1:0] sample_ch1;
  logic [SAMPLE_W-1:0] sample_ch2;
  logic [SAMPLE_W-1:0] sample_ch3;
  logic [SAMPLE_W-1:0] sample_ch4;
  logic [SAMPLE_W-1:0] sample_ch5;
  logic [SAMPLE_W-1:0] sample_ch6;
  logic [SAMPLE_W-1:0] sample_ch7;

  modport source (output valid, button_levels, sample_ch0, sample_ch1, sample_ch2,
                  sample_ch3, sample_ch4, sample_ch5, sample_ch6, sample_ch7,
                  input ready);
  modport sink (input valid, button_levels, sample_ch0, sample_ch1, sample_ch2,
                sample_ch3, sample_ch4, sample_ch5, sample_ch6, sample_ch7,
                output ready);
endinterface

interface mwap_result_if;
  import mwap_pkg::*;
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] light_outputs;
  logic [BTN_W-1:0] status_outputs;
  logic [BTN_W-1:0] alarm_latches;
  logic             alarm_output;

  modport source (output valid, light_outputs, status_outputs, alarm_latches,
                  alarm_output, input ready);
  modport sink (input valid, light_outputs, status_outputs, alarm_latches,
                alarm_output, output ready);
endinterface

`default_nettype wire

[src/mwap_press_qual.sv]
// Per-channel button press qualifier: hold counters and lock flags.
// Depends on mwap_pkg; reports which buttons act on the current tick.
`timescale 1ns / 1ps
`default_nettype none

module mwap_press_qual (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            advance,
  input  wire logic [mwap_pkg::CHANNELS-1:0]   buttons,
  input  wire logic [mwap_pkg::TICKS_W-1:0]    press_ticks,
  output logic      [mwap_pkg::CHANNELS-1:0]   act
);
  import mwap_pkg::*;

  logic [TICKS_W-1:0]  press_count      [CHANNELS];
  logic [TICKS_W-1:0]  press_count_next [CHANNELS];
  logic [CHANNELS-1:0] press_lock;
  logic [CHANNELS-1:0] press_lock_next;

  // Count while held and unlocked, drop lock on release, fire on threshold match
  always_comb begin
    logic [TICKS_W-1:0] cnt;
    logic               lck;
    for (int i = 0; i < CHANNELS; i++) begin
      cnt = press_count[i];
      lck = press_lock[i];
      if (buttons[i]) begin
        if (!lck) begin
          cnt = cnt + 1'b1;
        end
      end else begin
        lck = 1'b0;
      end
      act[i] = (cnt == press_ticks);
      press_count_next[i] = act[i] ? '0 : cnt;
      press_lock_next[i]  = lck | act[i];
    end
  end

  // Hold state between accepted ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      press_lock <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        press_count[i] <= '0;
      end
    end else if (advance) begin
      press_lock <= press_lock_next;
      for (int i = 0; i < CHANNELS; i++) begin
        press_count[i] <= press_count_next[i];
      end
    end
  end

endmodule

`default_nettype wire

[src/multichannel_window_alarm_panel_unit.sv]
// Top level of the multichannel window alarm panel.
// Depends on mwap_pkg, mwap_if (tick and result interfaces) and mwap_press_qual.
`timescale 1ns / 1ps
`default_nettype none

// One tick word is taken per clock cycle, sustained, and its result word
// appears in the output register on the next cycle; all channels are handled
// side by side, so the output register's handshake is the only thing that
// sets the rate: a tick is taken whenever the output register is empty or
// being drained in the same cycle. Configuration writes are registered and
// should only be issued while no tick is in flight. After reset the press
// threshold is 25 ticks, the window is 497..550 and the blink half period is
// 2000 ticks; no clearing pass is needed.
module multichannel_window_alarm_panel_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  mwap_tick_if.sink                              tick,
  mwap_result_if.source                          result,
  input  wire logic                              cfg_we,
  input  wire logic [mwap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mwap_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mwap_pkg::*;

  // Configuration registers
  logic [TICKS_W-1:0] press_ticks;
  logic [WIN_W-1:0]   window_high;
  logic [WIN_W-1:0]   window_low;
  logic [TICKS_W-1:0] blink_ticks;

  // Panel state
  logic [CHANNELS-1:0] armed_mask, armed_mask_next;
  logic [CHANNELS-1:0] alarm_mask, alarm_mask_next;
  logic [CHANNELS-1:0] status_mask, status_mask_next;
  logic                alarm_line, alarm_line_next;
  logic                blink_phase, blink_phase_next;
  logic [TICKS_W-1:0]  low_phase_count, low_phase_count_next;
  logic [TICKS_W-1:0]  high_phase_count, high_phase_count_next;

  logic                accept;
  logic [CHANNELS-1:0] act;
  logic [SAMPLE_W-1:0] samples [BTN_W];

  // Take a tick whenever the output register is free or draining
  assign tick.ready = !result.valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  assign samples[0] = tick.sample_ch0;
  assign samples[1] = tick.sample_ch1;
  assign samples[2] = tick.sample_ch2;
  assign samples[3] = tick.sample_ch3;
  assign samples[4] = tick.sample_ch4;
  assign samples[5] = tick.sample_ch5;
  assign samples[6] = tick.sample_ch6;
  assign samples[7] = tick.sample_ch7;

  // Load configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks <= PRESS_TICKS_RST;
      window_high <= WINDOW_HIGH_RST;
      window_low  <= WINDOW_LOW_RST;
      blink_ticks <= BLINK_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_TICKS: press_ticks <= cfg_data;
        REG_WINDOW_HIGH: window_high <= cfg_data[WIN_W-1:0];
        REG_WINDOW_LOW:  window_low  <= cfg_data[WIN_W-1:0];
        REG_BLINK_TICKS: blink_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  mwap_press_qual u_press_qual (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .buttons     (tick.button_levels[CHANNELS-1:0]),
    .press_ticks (press_ticks),
    .act         (act)
  );

  // Apply button actions, window trips, blink and the sticky line
  always_comb begin
    logic [TICKS_W-1:0] low_c;
    logic [TICKS_W-1:0] high_c;
    logic               ph;
    armed_mask_next  = armed_mask;
    alarm_mask_next  = alarm_mask;
    status_mask_next = status_mask;
    alarm_line_next  = alarm_line;

    // Button 0 clears alarms, the rest toggle arming
    for (int i = 0; i < CHANNELS; i++) begin
      if (act[i]) begin
        if (i == 0) begin
          alarm_mask_next = '0;
          alarm_line_next = 1'b0;
        end else if (armed_mask_next[i]) begin
          armed_mask_next[i]  = 1'b0;
          status_mask_next[i] = 1'b0;
        end else begin
          armed_mask_next[i]  = 1'b1;
          status_mask_next[i] = 1'b1;
        end
      end
    end

    // Trip armed channels whose sample leaves the window
    for (int i = 0; i < CHANNELS; i++) begin
      if (armed_mask_next[i] &&
          ((samples[i] > window_high) || (samples[i] < window_low))) begin
        armed_mask_next[i] = 1'b0;
        alarm_mask_next[i] = 1'b1;
      end
    end

    // Advance the blink counters; a high-count match wins over a low-count one
    if (!blink_phase) begin
      low_c  = low_phase_count + 1'b1;
      high_c = '0;
    end else begin
      low_c  = '0;
      high_c = high_phase_count + 1'b1;
    end
    ph = blink_phase;
    if (low_c == blink_ticks) begin
      ph = 1'b1;
    end
    if (high_c == blink_ticks) begin
      ph = 1'b0;
    end
    low_phase_count_next  = low_c;
    high_phase_count_next = high_c;
    blink_phase_next      = ph;

    // Alarmed status lamps follow the blink phase
    if (ph) begin
      status_mask_next = status_mask_next | alarm_mask_next;
    end else begin
      status_mask_next = status_mask_next & ~alarm_mask_next;
    end

    if (alarm_mask_next != '0) begin
      alarm_line_next = 1'b1;
    end
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_mask       <= '0;
      alarm_mask       <= '0;
      status_mask      <= '0;
      alarm_line       <= 1'b0;
      blink_phase      <= 1'b0;
      low_phase_count  <= '0;
      high_phase_count <= '0;
    end else if (accept) begin
      armed_mask       <= armed_mask_next;
      alarm_mask       <= alarm_mask_next;
      status_mask      <= status_mask_next;
      alarm_line       <= alarm_line_next;
      blink_phase      <= blink_phase_next;
      low_phase_count  <= low_phase_count_next;
      high_phase_count <= high_phase_count_next;
    end
  end

  // Output register: load a word on accept, hold it while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (tick.ready) begin
      result.valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.light_outputs  <= BTN_W'(armed_mask_next);
      result.status_outputs <= BTN_W'(status_mask_next);
      result.alarm_latches  <= BTN_W'(alarm_mask_next);
      result.alarm_output   <= alarm_line_next;
    end
  end

`ifndef SYNTHESIS
  // Any latched alarm keeps the sticky line up
  a_line_follows_mask: assert property (@(posedge clk) disable iff (rst)
    (alarm_mask != '0) |-> alarm_line)
    else $error("alarm line low while an alarm is latched");

  // A shown word with latched alarms carries the sticky line
  a_out_line: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.alarm_latches != '0)) |-> result.alarm_output)
    else $error("result word has latches but no alarm line");

  // An accepted tick produces a result word on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted tick produced no result word");
`endif

endmodule

`default_nettype wire

[bench/multichannel_window_alarm_panel_unit_tb.sv]
// Self-checking bench for the multichannel window alarm panel: drives tick words,
// predicts every result word and compares it. Depends on mwap_pkg, mwap_if and the RTL.
`timescale 1ns / 1ps

module multichannel_window_alarm_panel_unit_tb;
  import mwap_pkg::*;

  typedef struct packed {
    logic [BTN_W-1:0]                   buttons;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] samples;
  } tick_word_t;

  typedef struct packed {
    logic [BTN_W-1:0] lights;
    logic [BTN_W-1:0] lamps;
    logic [BTN_W-1:0] latches;
    logic             siren;
  } panel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Stimulus side, known from time zero
  logic                  tick_valid  = 1'b0;
  tick_word_t            tick_word   = '0;
  logic                  panel_ready = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  tick_word_t  pending_ticks [$];
  panel_word_t expected_panel [$];

  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned errors         = 0;
  logic        tick_taken     = 1'b0;
  int          backpressure_left = 0;
  bit          backpressure_done = 1'b0;

  // Panel prediction state and register copies
  logic [TICKS_W-1:0] press_run [CHANNELS];
  logic [BTN_W-1:0]   press_held;
  logic [BTN_W-1:0]   armed_bits;
  logic [BTN_W-1:0]   latch_bits;
  logic [BTN_W-1:0]   lamp_bits;
  logic               siren_line;
  logic               blink_on;
  logic [TICKS_W-1:0] dark_run;
  logic [TICKS_W-1:0] lit_run;
  logic [TICKS_W-1:0] press_thr;
  logic [WIN_W-1:0]   win_hi;
  logic [WIN_W-1:0]   win_lo;
  logic [TICKS_W-1:0] blink_half;

  panel_word_t got_word;
  panel_word_t want_word;

  // No random idling while this stretch of words goes through
  wire quiet = (accepted_total >= 700) && (accepted_total < 950);

  mwap_tick_if   tick_bus ();
  mwap_result_if result_bus ();

  assign tick_bus.valid         = tick_valid;
  assign tick_bus.button_levels = tick_word.buttons;
  assign tick_bus.sample_ch0    = tick_word.samples[0];
  assign tick_bus.sample_ch1    = tick_word.samples[1];
  assign tick_bus.sample_ch2    = tick_word.samples[2];
  assign tick_bus.sample_ch3    = tick_word.samples[3];
  assign tick_bus.sample_ch4    = tick_word.samples[4];
  assign tick_bus.sample_ch5    = tick_word.samples[5];
  assign tick_bus.sample_ch6    = tick_word.samples[6];
  assign tick_bus.sample_ch7    = tick_word.samples[7];
  assign result_bus.ready       = panel_ready;

  multichannel_window_alarm_panel_unit dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_bus),
    .result    (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the panel by one tick and return the word it reports
  task automatic step_panel(input tick_word_t w, output panel_word_t r);
    logic [SAMPLE_W-1:0] s;
    // Qualify button levels
    for (int i = 0; i < CHANNELS; i++) begin
      if (w.buttons[i]) begin
        if (!press_held[i]) press_run[i] = press_run[i] + 1'b1;
      end else begin
        press_held[i] = 1'b0;
      end
    end
    // Act on qualified presses, lowest channel first
    for (int i = 0; i < CHANNELS; i++) begin
      if (press_run[i] == press_thr) begin
        press_held[i] = 1'b1;
        press_run[i]  = '0;
        if (i == 0) begin
          latch_bits = '0;
          siren_line = 1'b0;
        end else if (armed_bits[i]) begin
          armed_bits[i] = 1'b0;
          lamp_bits[i]  = 1'b0;
        end else begin
          armed_bits[i] = 1'b1;
          lamp_bits[i]  = 1'b1;
        end
      end
    end
    // Trip armed channels outside the window
    for (int i = 0; i < CHANNELS; i++) begin
      s = w.samples[i];
      if (armed_bits[i] && (s > win_hi || s < win_lo)) begin
        armed_bits[i] = 1'b0;
        latch_bits[i] = 1'b1;
      end
    end
    // Advance the blink phase
    if (!blink_on) begin
      dark_run = dark_run + 1'b1;
      lit_run  = '0;
    end else begin
      dark_run = '0;
      lit_run  = lit_run + 1'b1;
    end
    if (dark_run == blink_half) blink_on = 1'b1;
    if (lit_run == blink_half) blink_on = 1'b0;
    // Latched channels' lamps follow the blink
    if (blink_on) lamp_bits = lamp_bits | latch_bits;
    else lamp_bits = lamp_bits & ~latch_bits;
    if (latch_bits != '0) siren_line = 1'b1;
    r.lights  = armed_bits;
    r.lamps   = lamp_bits;
    r.latches = latch_bits;
    r.siren   = siren_line;
  endtask

  // Monitor: track register writes, check result words, predict accepted ticks
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) press_run[i] = '0;
      press_held = '0;
      armed_bits = '0;
      latch_bits = '0;
      lamp_bits  = '0;
      siren_line = 1'b0;
      blink_on   = 1'b0;
      dark_run   = '0;
      lit_run    = '0;
      press_thr  = PRESS_TICKS_RST;
      win_hi     = WINDOW_HIGH_RST;
      win_lo     = WINDOW_LOW_RST;
      blink_half = BLINK_TICKS_RST;
      tick_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PRESS_TICKS: press_thr  = cfg_data;
          REG_WINDOW_HIGH: win_hi     = cfg_data[WIN_W-1:0];
          REG_WINDOW_LOW:  win_lo     = cfg_data[WIN_W-1:0];
          REG_BLINK_TICKS: blink_half = cfg_data;
          default: ;
        endcase
      end
      if (result_bus.valid && panel_ready) begin
        got_word.lights  = result_bus.light_outputs;
        got_word.lamps   = result_bus.status_outputs;
        got_word.latches = result_bus.alarm_latches;
        got_word.siren   = result_bus.alarm_output;
        if (expected_panel.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: lights %h lamps %h latches %h alarm %b",
                     got_word.lights, got_word.lamps, got_word.latches, got_word.siren);
        end else begin
          want_word = expected_panel.pop_front();
          if (got_word.lights !== want_word.lights || got_word.lamps !== want_word.lamps ||
              got_word.latches !== want_word.latches || got_word.siren !== want_word.siren)
          begin
            errors++;
            if (errors <= 10)
              $display("mismatch (exp/got): lights %h/%h lamps %h/%h latches %h/%h alarm %b/%b",
                       want_word.lights, got_word.lights, want_word.lamps, got_word.lamps,
                       want_word.latches, got_word.latches, want_word.siren, got_word.siren);
          end
        end
      end
      if (tick_valid && tick_bus.ready) begin
        step_panel(tick_word, want_word);
        expected_panel.push_back(want_word);
        accepted_total++;
        tick_taken <= 1'b1;
      end else begin
        tick_taken <= 1'b0;
      end
    end
  end

  // Driver: hold the word until taken, then offer the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!tick_valid || tick_taken) begin
      if (pending_ticks.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
        tick_word  <= pending_ticks.pop_front();
        tick_valid <= 1'b1;
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // Hold off the receiver once for a long stretch so the input stalls
  always @(negedge clk) begin
    if (rst) begin
      backpressure_left <= 0;
    end else if (backpressure_left != 0) begin
      backpressure_left <= backpressure_left - 1;
    end else if (!backpressure_done && accepted_total >= 400) begin
      backpressure_left <= 300;
      backpressure_done <= 1'b1;
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (rst) begin
      panel_ready <= 1'b0;
    end else begin
      panel_ready <= (backpressure_left == 0) && (quiet || $urandom_range(99) >= 6);
    end
  end

  function automatic logic [CHANNELS-1:0][SAMPLE_W-1:0] level(input int v);
    return {CHANNELS{SAMPLE_W'(v)}};
  endfunction

  task automatic add_tick(input tick_word_t w);
    pending_ticks.push_back(w);
    queued_total++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_total != queued_total || expected_panel.size() != 0);
  endtask

  // Write all four registers while nothing is in flight
  task automatic program_panel(input int press, input int hi, input int lo, input int blink);
    wait_drained();
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PRESS_TICKS;
    cfg_data  <= CFG_DATA_W'(press);
    @(negedge clk);
    cfg_index <= REG_WINDOW_HIGH;
    cfg_data  <= CFG_DATA_W'(hi);
    @(negedge clk);
    cfg_index <= REG_WINDOW_LOW;
    cfg_data  <= CFG_DATA_W'(lo);
    @(negedge clk);
    cfg_index <= REG_BLINK_TICKS;
    cfg_data  <= CFG_DATA_W'(blink);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Button presses held for a few ticks, samples mostly inside the window unless it is inverted
  task automatic run_phase(input int press, input int hi, input int lo, input int blink,
                           input int count);
    int               roll;
    int               run_left;
    logic [BTN_W-1:0] btn;
    tick_word_t       w;
    run_left = 0;
    btn      = '0;
    program_panel(press, hi, lo, blink);
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        roll = $urandom_range(99);
        if (roll < 10) btn = BTN_W'($urandom);
        else if (roll < 35) btn = '0;
        else btn = btn ^ (BTN_W'(1) << $urandom_range(BTN_W - 1));
        run_left = $urandom_range(10, 1);
      end
      run_left--;
      w.buttons = btn;
      for (int c = 0; c < CHANNELS; c++) begin
        roll = $urandom_range(99);
        if (roll < 3 || lo > hi) w.samples[c] = SAMPLE_W'($urandom);
        else if (roll < 4) w.samples[c] = $urandom_range(1) ? {SAMPLE_W{1'b1}} : '0;
        else w.samples[c] = SAMPLE_W'($urandom_range(hi, lo));
      end
      add_tick(w);
    end
  endtask

  initial begin
    tick_word_t w;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: arm, window edges, trips, clear, lock, disarm
    program_panel(1, 550, 497, 1);
    w.buttons = 8'hFE;
    w.samples = level(520);
    add_tick(w);
    w.buttons = '0;
    w.samples = level(497);
    add_tick(w);
    w.samples = level(550);
    add_tick(w);
    w.samples    = level(520);
    w.samples[1] = 10'd496;
    w.samples[2] = 10'd551;
    w.samples[3] = '0;
    w.samples[4] = '1;
    add_tick(w);
    w.buttons = 8'h01;
    w.samples = level(520);
    add_tick(w);
    w.buttons = '0;
    w.samples = level(1023);
    add_tick(w);
    w.buttons = 8'hFF;
    w.samples = level(0);
    add_tick(w);
    w.samples = level(520);
    add_tick(w);
    w.buttons = '0;
    add_tick(w);
    w.buttons = 8'hAA;
    add_tick(w);
    w.buttons = '0;
    add_tick(w);
    w.buttons = 8'h0A;
    add_tick(w);
    w.buttons = '0;
    w.samples = {4{10'h155, 10'h2AA}};
    add_tick(w);
    w.buttons = 8'h55;
    w.samples = level(520);
    add_tick(w);
    w.buttons = '0;
    w.samples = {4{10'h2AA, 10'h155}};
    add_tick(w);
    w.buttons = 8'h80;
    w.samples = level(520);
    add_tick(w);
    w.buttons = '0;
    add_tick(w);
    add_tick(w);

    // Random phases, including inverted window and zero thresholds
    run_phase(2, 600, 450, 3, 300);
    run_phase(3, 100, 900, 5, 200);
    run_phase(4, 1023, 0, 7, 300);
    run_phase(6, 550, 497, 2, 300);
    run_phase(0, 0, 0, 0, 150);
    run_phase(65535, 1023, 1023, 65535, 150);

    wait_drained();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
